// ----- rtl/bmirq_pkg.sv -----
// Shared types and constants for the bank mapper with IRQ counter.
package bmirq_pkg;

   localparam logic [1:0] OP_CPU_WRITE = 2'd0;
   localparam logic [1:0] OP_CPU_READ  = 2'd1;
   localparam logic [1:0] OP_PPU_FETCH = 2'd2;
   localparam logic [1:0] OP_TICK      = 2'd3;

   localparam logic [1:0] SEL_NONE = 2'd0;
   localparam logic [1:0] SEL_PRG  = 2'd1;
   localparam logic [1:0] SEL_WRAM = 2'd2;
   localparam logic [1:0] SEL_CHR  = 2'd3;

   localparam logic [2:0] CSR_PRG_AND_MASK  = 3'd0;
   localparam logic [2:0] CSR_PRG_OR_VALUE  = 3'd1;
   localparam logic [2:0] CSR_CHR_AND_MASK  = 3'd2;
   localparam logic [2:0] CSR_CHR_OR_VALUE  = 3'd3;
   localparam logic [2:0] CSR_WRAM_PRESENT  = 3'd4;
   localparam logic [2:0] CSR_WRAM_OR_VALUE = 3'd5;

   localparam logic [7:0]  PRG_AND_MASK_RESET  = 8'd63;
   localparam logic [11:0] PRG_OR_VALUE_RESET  = 12'd0;
   localparam logic [7:0]  CHR_AND_MASK_RESET  = 8'd255;
   localparam logic [11:0] CHR_OR_VALUE_RESET  = 12'd0;
   localparam logic        WRAM_PRESENT_RESET  = 1'b1;
   localparam logic [11:0] WRAM_OR_VALUE_RESET = 12'd0;

   localparam int          NUM_REGS        = 16;
   localparam logic [3:0]  REG_WRAM_CTRL   = 4'd8;
   localparam logic [3:0]  REG_PRG_BASE    = 4'd9;
   localparam logic [3:0]  REG_MIRROR      = 4'd12;
   localparam logic [3:0]  REG_IRQ_CTRL    = 4'd13;
   localparam logic [3:0]  REG_CNT_LOW     = 4'd14;
   localparam logic [3:0]  REG_CNT_HIGH    = 4'd15;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  data;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  mem_select;
      logic [11:0] bank;
      logic        write_allowed;
      logic [7:0]  open_bus_data;
      logic        irq;
      logic [1:0]  mirroring;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] wram_ctrl;
      logic [7:0] bank_reg;
      logic       irq;
      logic [1:0] mirroring;
   } regs_view_type;

endpackage

// ----- rtl/bmirq_regs.sv -----
// Mapper register file, register index, IRQ counter and IRQ flag.
module bmirq_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  bmirq_pkg::req_item_type item,
   output bmirq_pkg::regs_view_type view
);

   logic [7:0]  regs_ff [bmirq_pkg::NUM_REGS];
   logic [7:0]  regs_in [bmirq_pkg::NUM_REGS];
   logic [3:0]  index_ff;
   logic [3:0]  index_in;
   logic        irq_ff;
   logic        irq_in;
   logic [15:0] count_dec;
   logic [3:0]  rd_index;
   logic        reg_area;

   assign count_dec = {regs_ff[bmirq_pkg::REG_CNT_HIGH], regs_ff[bmirq_pkg::REG_CNT_LOW]}
                      - 16'd1;
   assign reg_area  = (item.operation == bmirq_pkg::OP_CPU_WRITE) &&
                      (item.address[15:14] == 2'b10);

   always_comb begin
      regs_in  = regs_ff;
      index_in = index_ff;
      irq_in   = irq_ff;
      if (reg_area) begin
         if (item.address[13]) begin
            regs_in[index_ff] = item.data;
            if (index_ff == bmirq_pkg::REG_IRQ_CTRL) begin
               irq_in = 1'b0;
            end
         end else begin
            index_in = item.data[3:0];
         end
      end else if ((item.operation == bmirq_pkg::OP_TICK) &&
                   regs_ff[bmirq_pkg::REG_IRQ_CTRL][7]) begin
         regs_in[bmirq_pkg::REG_CNT_LOW]  = count_dec[7:0];
         regs_in[bmirq_pkg::REG_CNT_HIGH] = count_dec[15:8];
         if ((count_dec == 16'd0) && regs_ff[bmirq_pkg::REG_IRQ_CTRL][0]) begin
            irq_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bmirq_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= 8'd0;
         end
         index_ff <= 4'd0;
         irq_ff   <= 1'b0;
      end else if (step) begin
         regs_ff  <= regs_in;
         index_ff <= index_in;
         irq_ff   <= irq_in;
      end
   end

   // Character fetches read registers 0 to 7, program reads registers 9 to 11.
   assign rd_index = (item.operation == bmirq_pkg::OP_PPU_FETCH) ?
                     {1'b0, item.address[12:10]} :
                     bmirq_pkg::REG_PRG_BASE + {2'b00, item.address[14:13]};

   assign view.wram_ctrl = regs_ff[bmirq_pkg::REG_WRAM_CTRL];
   assign view.bank_reg  = regs_ff[rd_index];
   assign view.irq       = irq_in;
   assign view.mirroring = regs_in[bmirq_pkg::REG_MIRROR][1:0];

endmodule

// ----- rtl/bank_mapper_with_irq_counter.sv -----
// Top level of the bank mapper with indexed registers and an IRQ down-counter.
//
//   channel  direction  ports          carries
//   req      in         req_*          one bus access or one cpu cycle tick
//   rsp      out        rsp_*          translated target, bank, irq and mirroring
//   csr      in         csr_*          writes to the six configuration registers
//
// An item is registered on acceptance and its result is registered when it advances.
// One item per cycle is sustained while rsp_ready is high.
// Reset clears the mapper registers, index and IRQ flag and presets the configuration.
// A stalled result holds, and the input register still takes an item while it is empty.
module bank_mapper_with_irq_counter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bmirq_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bmirq_pkg::rsp_item_type rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [11:0]             csr_data
);

   logic [7:0]  prg_and_mask_ff;
   logic [11:0] prg_or_value_ff;
   logic [7:0]  chr_and_mask_ff;
   logic [11:0] chr_or_value_ff;
   logic        wram_present_ff;
   logic [11:0] wram_or_value_ff;

   logic                     in_valid_ff;
   bmirq_pkg::req_item_type  in_item_ff;
   logic                     out_valid_ff;
   bmirq_pkg::rsp_item_type  out_item_ff;
   bmirq_pkg::rsp_item_type  out_item_in;
   bmirq_pkg::regs_view_type view;
   logic                     advance;

   logic [15:0] addr;
   logic [7:0]  r8;
   logic        wram_slot;
   logic [11:0] prg_ctrl_bank;
   logic [11:0] prg_slot_bank;
   logic [11:0] prg_last_bank;
   logic [11:0] wram_bank;
   logic [11:0] chr_bank;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_and_mask_ff  <= bmirq_pkg::PRG_AND_MASK_RESET;
         prg_or_value_ff  <= bmirq_pkg::PRG_OR_VALUE_RESET;
         chr_and_mask_ff  <= bmirq_pkg::CHR_AND_MASK_RESET;
         chr_or_value_ff  <= bmirq_pkg::CHR_OR_VALUE_RESET;
         wram_present_ff  <= bmirq_pkg::WRAM_PRESENT_RESET;
         wram_or_value_ff <= bmirq_pkg::WRAM_OR_VALUE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            bmirq_pkg::CSR_PRG_AND_MASK:  prg_and_mask_ff  <= csr_data[7:0];
            bmirq_pkg::CSR_PRG_OR_VALUE:  prg_or_value_ff  <= csr_data;
            bmirq_pkg::CSR_CHR_AND_MASK:  chr_and_mask_ff  <= csr_data[7:0];
            bmirq_pkg::CSR_CHR_OR_VALUE:  chr_or_value_ff  <= csr_data;
            bmirq_pkg::CSR_WRAM_PRESENT:  wram_present_ff  <= csr_data[0];
            bmirq_pkg::CSR_WRAM_OR_VALUE: wram_or_value_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   bmirq_regs u_regs (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .view  (view)
   );

   assign addr          = in_item_ff.address;
   assign r8            = view.wram_ctrl;
   assign wram_slot     = (addr[15:13] == 3'b011);
   assign prg_ctrl_bank = {4'd0, r8 & prg_and_mask_ff} | prg_or_value_ff;
   assign prg_slot_bank = {4'd0, view.bank_reg & prg_and_mask_ff} | prg_or_value_ff;
   assign prg_last_bank = {4'd0, prg_and_mask_ff} | prg_or_value_ff;
   assign wram_bank     = {4'd0, r8} | wram_or_value_ff;
   assign chr_bank      = {4'd0, view.bank_reg & chr_and_mask_ff} | chr_or_value_ff;

   always_comb begin
      out_item_in               = '0;
      out_item_in.irq           = view.irq;
      out_item_in.mirroring     = view.mirroring;
      unique case (in_item_ff.operation)
         bmirq_pkg::OP_CPU_WRITE: begin
            if (wram_slot) begin
               if (!r8[6]) begin
                  out_item_in.mem_select = bmirq_pkg::SEL_PRG;
                  out_item_in.bank       = prg_ctrl_bank;
               end else if (wram_present_ff) begin
                  out_item_in.mem_select    = bmirq_pkg::SEL_WRAM;
                  out_item_in.bank          = wram_bank;
                  out_item_in.write_allowed = r8[7];
               end
            end
         end
         bmirq_pkg::OP_CPU_READ: begin
            if (wram_slot) begin
               if (!r8[6]) begin
                  out_item_in.mem_select = bmirq_pkg::SEL_PRG;
                  out_item_in.bank       = prg_ctrl_bank;
               end else if (wram_present_ff && r8[7]) begin
                  out_item_in.mem_select = bmirq_pkg::SEL_WRAM;
                  out_item_in.bank       = wram_bank;
               end else begin
                  out_item_in.open_bus_data = addr[15:8];
               end
            end else if (addr[15]) begin
               out_item_in.mem_select = bmirq_pkg::SEL_PRG;
               out_item_in.bank       = (addr[14:13] == 2'b11) ? prg_last_bank : prg_slot_bank;
            end
         end
         bmirq_pkg::OP_PPU_FETCH: begin
            if (!addr[13]) begin
               out_item_in.mem_select = bmirq_pkg::SEL_CHR;
               out_item_in.bank       = chr_bank;
            end
         end
         bmirq_pkg::OP_TICK: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ----- rtl/bmirq_checker.sv -----
// Port-level checks for the bank mapper top level, bound to it below.
module bmirq_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input bmirq_pkg::rsp_item_type rsp_item
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled rsp item changed");

   a_write_only_wram: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.write_allowed |-> rsp_item.mem_select == bmirq_pkg::SEL_WRAM)
      else $error("write allowed outside work RAM");

   a_open_bus_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.open_bus_data != 8'd0) |->
      rsp_item.mem_select == bmirq_pkg::SEL_NONE && rsp_item.bank == 12'd0)
      else $error("open bus data with a memory target");

endmodule

bind bank_mapper_with_irq_counter bmirq_checker u_bmirq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the bank mapper with indexed registers and IRQ down-counter.
module tb;

   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int PHASE_ITEMS = 70;
   localparam int NUM_PHASES = 6;

   typedef struct {
      bmirq_pkg::req_item_type item;
      bit                      typed;
      bmirq_pkg::rsp_item_type want;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   bmirq_pkg::req_item_type req_item;
   logic                    rsp_valid;
   logic                    rsp_ready;
   bmirq_pkg::rsp_item_type rsp_item;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [2:0]              csr_index;
   logic [11:0]             csr_data;

   bit                      row_typed;
   bmirq_pkg::rsp_item_type row_want;
   bit                      idle_on;
   int                      errors;
   int                      items_sent;
   bmirq_pkg::rsp_item_type predicted_results [$];
   stim_row_type            directed_rows [$];

   logic [7:0]   m_prg_and;
   logic [11:0]  m_prg_or;
   logic [7:0]   m_chr_and;
   logic [11:0]  m_chr_or;
   logic         m_wram_present;
   logic [11:0]  m_wram_or;
   logic [3:0]   m_index;
   logic [7:0]   m_regs [bmirq_pkg::NUM_REGS];
   logic         m_irq;

   bank_mapper_with_irq_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [11:0] prg_map(input logic [7:0] r);
      return {4'h0, r & m_prg_and} | m_prg_or;
   endfunction

   function automatic bmirq_pkg::rsp_item_type translate_access(
         input bmirq_pkg::req_item_type it);
      bmirq_pkg::rsp_item_type r;
      logic [7:0]   wctl;
      logic [15:0]  cnt;
      logic [1:0]   slot;
      logic [3:0]   ridx;
      r = '0;
      wctl = m_regs[bmirq_pkg::REG_WRAM_CTRL];
      case (it.operation)
         bmirq_pkg::OP_CPU_WRITE: begin
            if (it.address[15:13] == 3'b011) begin
               if (!wctl[6]) begin
                  r.mem_select = bmirq_pkg::SEL_PRG;
                  r.bank = prg_map(wctl);
               end else if (m_wram_present) begin
                  r.mem_select = bmirq_pkg::SEL_WRAM;
                  r.bank = {4'h0, wctl} | m_wram_or;
                  r.write_allowed = wctl[7];
               end
            end else if (it.address[15:14] == 2'b10) begin
               if (it.address[13]) begin
                  m_regs[m_index] = it.data;
                  if (m_index == bmirq_pkg::REG_IRQ_CTRL) m_irq = 1'b0;
               end else begin
                  m_index = it.data[3:0];
               end
            end
         end
         bmirq_pkg::OP_CPU_READ: begin
            if (it.address[15:13] == 3'b011) begin
               if (!wctl[6]) begin
                  r.mem_select = bmirq_pkg::SEL_PRG;
                  r.bank = prg_map(wctl);
               end else if (m_wram_present && wctl[7]) begin
                  r.mem_select = bmirq_pkg::SEL_WRAM;
                  r.bank = {4'h0, wctl} | m_wram_or;
               end else begin
                  r.open_bus_data = it.address[15:8];
               end
            end else if (it.address[15]) begin
               slot = it.address[14:13];
               ridx = 4'(bmirq_pkg::REG_PRG_BASE + slot);
               r.mem_select = bmirq_pkg::SEL_PRG;
               r.bank = (slot == 2'd3) ? prg_map(8'hFF) : prg_map(m_regs[ridx]);
            end
         end
         bmirq_pkg::OP_PPU_FETCH: begin
            if (!it.address[13]) begin
               r.mem_select = bmirq_pkg::SEL_CHR;
               r.bank = {4'h0, m_regs[{1'b0, it.address[12:10]}] & m_chr_and} | m_chr_or;
            end
         end
         default: begin
            if (m_regs[bmirq_pkg::REG_IRQ_CTRL][7]) begin
               cnt = {m_regs[bmirq_pkg::REG_CNT_HIGH], m_regs[bmirq_pkg::REG_CNT_LOW]} - 16'd1;
               if (cnt == 16'd0 && m_regs[bmirq_pkg::REG_IRQ_CTRL][0]) m_irq = 1'b1;
               m_regs[bmirq_pkg::REG_CNT_LOW] = cnt[7:0];
               m_regs[bmirq_pkg::REG_CNT_HIGH] = cnt[15:8];
            end
         end
      endcase
      r.irq = m_irq;
      r.mirroring = m_regs[bmirq_pkg::REG_MIRROR][1:0];
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      bmirq_pkg::rsp_item_type want;
      bmirq_pkg::rsp_item_type pred;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bmirq_pkg::CSR_PRG_AND_MASK:  m_prg_and = csr_data[7:0];
               bmirq_pkg::CSR_PRG_OR_VALUE:  m_prg_or = csr_data;
               bmirq_pkg::CSR_CHR_AND_MASK:  m_chr_and = csr_data[7:0];
               bmirq_pkg::CSR_CHR_OR_VALUE:  m_chr_or = csr_data;
               bmirq_pkg::CSR_WRAM_PRESENT:  m_wram_present = csr_data[0];
               bmirq_pkg::CSR_WRAM_OR_VALUE: m_wram_or = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual %p", $time, rsp_item);
            end else begin
               want = predicted_results.pop_front();
               check_field("mem_select", want.mem_select, rsp_item.mem_select);
               check_field("bank", want.bank, rsp_item.bank);
               check_field("write_allowed", want.write_allowed, rsp_item.write_allowed);
               check_field("open_bus_data", want.open_bus_data, rsp_item.open_bus_data);
               check_field("irq", want.irq, rsp_item.irq);
               check_field("mirroring", want.mirroring, rsp_item.mirroring);
            end
         end
         if (req_valid && req_ready) begin
            pred = translate_access(req_item);
            predicted_results.push_back(row_typed ? row_want : pred);
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_req(input bmirq_pkg::req_item_type it, input bit typed,
                           input bmirq_pkg::rsp_item_type want);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      row_typed <= typed;
      row_want <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
      bmirq_pkg::req_item_type it;
      it.operation = op;
      it.address = addr;
      it.data = data;
      send_req(it, 1'b0, '0);
   endtask

   function automatic stim_row_type plain_row(input logic [1:0] op, input logic [15:0] addr,
                                              input logic [7:0] data);
      stim_row_type row;
      row.item.operation = op;
      row.item.address = addr;
      row.item.data = data;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [1:0] op, input logic [15:0] addr,
                                              input logic [7:0] data, input logic [1:0] sel,
                                              input logic [11:0] bank);
      stim_row_type row;
      row = plain_row(op, addr, data);
      row.typed = 1'b1;
      row.want.mem_select = sel;
      row.want.bank = bank;
      return row;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_burst();
      int          pick;
      logic [3:0]  idx;
      logic [7:0]  value;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 3))
            0: idx = 4'($urandom_range(0, 15));
            1: idx = bmirq_pkg::REG_WRAM_CTRL;
            2: idx = bmirq_pkg::REG_IRQ_CTRL;
            default: idx = ($urandom_range(0, 1) == 0) ? bmirq_pkg::REG_CNT_LOW
                                                       : bmirq_pkg::REG_CNT_HIGH;
         endcase
         value = 8'($urandom);
         if ($urandom_range(0, 1) == 0) begin
            if (idx == bmirq_pkg::REG_CNT_LOW) value = 8'($urandom_range(0, 6));
            else if (idx == bmirq_pkg::REG_CNT_HIGH) value = 8'h00;
            else if (idx == bmirq_pkg::REG_IRQ_CTRL) value = value | 8'h81;
         end
         send_plain(bmirq_pkg::OP_CPU_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h1FFF)),
                    {4'($urandom), idx});
         send_plain(bmirq_pkg::OP_CPU_WRITE, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)),
                    value);
      end else if (pick < 55) begin
         repeat ($urandom_range(1, 8))
            send_plain(bmirq_pkg::OP_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 75) begin
         if ($urandom_range(0, 1) == 0)
            send_plain(bmirq_pkg::OP_CPU_READ, 16'h6000 | 16'($urandom_range(0, 16'h1FFF)),
                       8'($urandom));
         else
            send_plain(bmirq_pkg::OP_CPU_READ, 16'($urandom), 8'($urandom));
      end else if (pick < 85) begin
         send_plain(bmirq_pkg::OP_CPU_WRITE, 16'h6000 | 16'($urandom_range(0, 16'h1FFF)),
                    8'($urandom));
      end else if (pick < 95) begin
         send_plain(bmirq_pkg::OP_PPU_FETCH, 16'($urandom), 8'($urandom));
      end else begin
         send_plain(2'($urandom), 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int          start;
      stim_row_type row;
      logic [11:0] cfg [6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      row_typed = 1'b0;
      row_want = '0;
      idle_on = 1'b1;
      errors = 0;
      items_sent = 0;
      m_prg_and = bmirq_pkg::PRG_AND_MASK_RESET;
      m_prg_or = bmirq_pkg::PRG_OR_VALUE_RESET;
      m_chr_and = bmirq_pkg::CHR_AND_MASK_RESET;
      m_chr_or = bmirq_pkg::CHR_OR_VALUE_RESET;
      m_wram_present = bmirq_pkg::WRAM_PRESENT_RESET;
      m_wram_or = bmirq_pkg::WRAM_OR_VALUE_RESET;
      m_index = '0;
      m_irq = 1'b0;
      foreach (m_regs[i]) m_regs[i] = '0;

      directed_rows.push_back(known_row(bmirq_pkg::OP_CPU_READ, 16'h0000, 8'h00,
                                        bmirq_pkg::SEL_NONE, 12'd0));
      directed_rows.push_back(known_row(bmirq_pkg::OP_CPU_READ, 16'h6000, 8'h00,
                                        bmirq_pkg::SEL_PRG, 12'd0));
      directed_rows.push_back(known_row(bmirq_pkg::OP_CPU_READ, 16'hE000, 8'h00,
                                        bmirq_pkg::SEL_PRG, 12'd63));
      directed_rows.push_back(known_row(bmirq_pkg::OP_CPU_READ, 16'hFFFF, 8'hFF,
                                        bmirq_pkg::SEL_PRG, 12'd63));
      directed_rows.push_back(known_row(bmirq_pkg::OP_PPU_FETCH, 16'h0000, 8'h00,
                                        bmirq_pkg::SEL_CHR, 12'd0));
      directed_rows.push_back(known_row(bmirq_pkg::OP_PPU_FETCH, 16'h3FFF, 8'hFF,
                                        bmirq_pkg::SEL_NONE, 12'd0));
      directed_rows.push_back(known_row(bmirq_pkg::OP_TICK, 16'hFFFF, 8'hFF,
                                        bmirq_pkg::SEL_NONE, 12'd0));
      directed_rows.push_back(known_row(bmirq_pkg::OP_CPU_WRITE, 16'h5FFF, 8'hFF,
                                        bmirq_pkg::SEL_NONE, 12'd0));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h8000, 8'h08));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hA000, 8'hC5));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_READ, 16'h7FFF, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h6123, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hBFFF, 8'h40));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_READ, 16'h7ABC, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h6000, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h9FFF, 8'h1C));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hA000, 8'h03));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h8000, 8'h0F));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hA000, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h8000, 8'h0E));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hA000, 8'h02));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'h8000, 8'h0D));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hA000, 8'h81));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_TICK, 16'h0000, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_TICK, 16'h0000, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_TICK, 16'h0000, 8'h00));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hA000, 8'h81));
      directed_rows.push_back(plain_row(bmirq_pkg::OP_CPU_WRITE, 16'hC000, 8'h55));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_req(row.item, row.typed, row.want);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         idle_on = (ph != NUM_PHASES - 1);
         case (ph)
            0: foreach (cfg[i]) cfg[i] = 12'h000;
            1: foreach (cfg[i]) cfg[i] = 12'hFFF;
            default: foreach (cfg[i]) cfg[i] = 12'($urandom);
         endcase
         if (ph >= 3) cfg[bmirq_pkg::CSR_WRAM_PRESENT] = 12'h001;
         if (ph == 2) cfg[bmirq_pkg::CSR_WRAM_PRESENT] = 12'h000;
         write_csr(bmirq_pkg::CSR_PRG_AND_MASK, cfg[bmirq_pkg::CSR_PRG_AND_MASK]);
         write_csr(bmirq_pkg::CSR_PRG_OR_VALUE, cfg[bmirq_pkg::CSR_PRG_OR_VALUE]);
         write_csr(bmirq_pkg::CSR_CHR_AND_MASK, cfg[bmirq_pkg::CSR_CHR_AND_MASK]);
         write_csr(bmirq_pkg::CSR_CHR_OR_VALUE, cfg[bmirq_pkg::CSR_CHR_OR_VALUE]);
         write_csr(bmirq_pkg::CSR_WRAM_PRESENT, cfg[bmirq_pkg::CSR_WRAM_PRESENT]);
         write_csr(bmirq_pkg::CSR_WRAM_OR_VALUE, cfg[bmirq_pkg::CSR_WRAM_OR_VALUE]);
         if (ph == 3) write_csr(CSR_UNUSED, 12'($urandom));
         csr_valid <= 1'b0;
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) random_burst();
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bmirq_pkg.sv
rtl/bmirq_regs.sv
rtl/bank_mapper_with_irq_counter.sv
rtl/bmirq_checker.sv
verif/tb.sv
